@@ hw/rtl/psot_pkg.sv @@
// Shared types and operation codes for the planar shape overlap test unit.
`timescale 1ns / 1ps

package psot_pkg;

	// Test selection carried with each request
	typedef enum logic [2:0] {
		OP_PT_BOX    = 3'd0,
		OP_BOX_BOX   = 3'd1,
		OP_BOX_CIRC  = 3'd2,
		OP_PT_CIRC   = 3'd3,
		OP_CIRC_CIRC = 3'd4
	} op_t;

	// Control bits passed from the prepare stage to the evaluate stage
	typedef struct packed {
		logic enable;       // operation known and shapes present, or presence ignored
		logic box_hit;      // box comparison already settled a hit
		logic corner_test;  // test the four box corners against the circle
		logic single_test;  // test the first distance pair against the radius
	} stage_ctrl_t;

endpackage

@@ hw/rtl/psot_prep.sv @@
// Prepare stage: center differences, box comparisons and distance squares.
`timescale 1ns / 1ps

module psot_prep #(
	parameter int COORD_BITS = 24
) (
	input  logic [2:0]                     operation,
	input  logic signed [COORD_BITS-1:0]   a_x,
	input  logic signed [COORD_BITS-1:0]   a_y,
	input  logic [COORD_BITS-2:0]          a_half_w,
	input  logic [COORD_BITS-2:0]          a_half_h,
	input  logic                           a_exist,
	input  logic signed [COORD_BITS-1:0]   b_x,
	input  logic signed [COORD_BITS-1:0]   b_y,
	input  logic [COORD_BITS-2:0]          b_half_w,
	input  logic [COORD_BITS-2:0]          b_half_h,
	input  logic                           b_exist,
	input  logic                           ignore_presence,
	output psot_pkg::stage_ctrl_t          ctrl,
	output logic [2*(COORD_BITS+1)-1:0]    sq_x0,
	output logic [2*(COORD_BITS+1)-1:0]    sq_x1,
	output logic [2*(COORD_BITS+1)-1:0]    sq_y0,
	output logic [2*(COORD_BITS+1)-1:0]    sq_y1,
	output logic [2*COORD_BITS-1:0]        sq_r
);
	import psot_pkg::*;

	localparam int DW = COORD_BITS + 2;   // signed difference width
	localparam int MW = COORD_BITS + 1;   // magnitude width
	localparam int SW = 2 * MW;           // square width
	localparam int RW = 2 * COORD_BITS;   // squared radius width

	function automatic logic [MW-1:0] mag_f(input logic signed [DW-1:0] v);
		logic signed [DW-1:0] n;
		n = -v;
		return v[DW-1] ? MW'(n) : MW'(v);
	endfunction

	op_t                     op;
	logic signed [DW-1:0]    ax_w, ay_w, bx_w, by_w, aw_w, ah_w;
	logic signed [DW-1:0]    d_x, d_y, lo_x, hi_x, lo_y, hi_y;
	logic signed [DW-1:0]    dx0, dy0;
	logic [MW-1:0]           m_dx, m_dy, m_x0, m_x1, m_y0, m_y1;
	logic [COORD_BITS-1:0]   aw_p_bw, ah_p_bw, ah_p_bh, r_sel;
	logic                    b_is_shape;

	assign op = op_t'(operation);

	// Widen coordinates and extents
	assign ax_w = DW'(a_x);
	assign ay_w = DW'(a_y);
	assign bx_w = DW'(b_x);
	assign by_w = DW'(b_y);
	assign aw_w = $signed(DW'(a_half_w));
	assign ah_w = $signed(DW'(a_half_h));

	// Center differences and box corner offsets relative to B
	assign d_x  = bx_w - ax_w;
	assign d_y  = by_w - ay_w;
	assign lo_x = ax_w - aw_w - bx_w;
	assign hi_x = ax_w + aw_w - bx_w;
	assign lo_y = ay_w - ah_w - by_w;
	assign hi_y = ay_w + ah_w - by_w;

	assign aw_p_bw = COORD_BITS'(a_half_w) + COORD_BITS'(b_half_w);
	assign ah_p_bw = COORD_BITS'(a_half_h) + COORD_BITS'(b_half_w);
	assign ah_p_bh = COORD_BITS'(a_half_h) + COORD_BITS'(b_half_h);

	assign m_dx = mag_f(d_x);
	assign m_dy = mag_f(d_y);

	// Corners for box against circle, plain center difference otherwise
	assign dx0  = (op == OP_BOX_CIRC) ? lo_x : d_x;
	assign dy0  = (op == OP_BOX_CIRC) ? lo_y : d_y;
	assign m_x0 = mag_f(dx0);
	assign m_x1 = mag_f(hi_x);
	assign m_y0 = mag_f(dy0);
	assign m_y1 = mag_f(hi_y);

	assign b_is_shape = op inside {OP_BOX_BOX, OP_BOX_CIRC, OP_CIRC_CIRC};

	// Decode the test and settle the box comparisons
	always_comb begin
		ctrl        = '0;
		r_sel       = '0;
		ctrl.enable = (operation <= OP_CIRC_CIRC) &&
			(ignore_presence || (a_exist && (b_exist || !b_is_shape)));
		unique case (op)
			OP_PT_BOX: begin
				ctrl.box_hit = (m_dx <= MW'(a_half_w)) && (m_dy <= MW'(a_half_h));
			end
			OP_BOX_BOX: begin
				ctrl.box_hit = (m_dx <= MW'(aw_p_bw)) && (m_dy <= MW'(ah_p_bh));
			end
			OP_BOX_CIRC: begin
				ctrl.box_hit =
					((m_dx <= MW'(a_half_w)) && (m_dy <= MW'(ah_p_bw))) ||
					((m_dx <= MW'(aw_p_bw)) && (m_dy <= MW'(a_half_h)));
				ctrl.corner_test = 1'b1;
				r_sel = COORD_BITS'(b_half_w);
			end
			OP_PT_CIRC: begin
				ctrl.single_test = 1'b1;
				r_sel = COORD_BITS'(a_half_w);
			end
			OP_CIRC_CIRC: begin
				ctrl.single_test = 1'b1;
				r_sel = aw_p_bw;
			end
			default: begin
				ctrl.box_hit = 1'b0;
			end
		endcase
	end

	// Squares of the distance components and the radius
	assign sq_x0 = SW'(m_x0) * SW'(m_x0);
	assign sq_x1 = SW'(m_x1) * SW'(m_x1);
	assign sq_y0 = SW'(m_y0) * SW'(m_y0);
	assign sq_y1 = SW'(m_y1) * SW'(m_y1);
	assign sq_r  = RW'(r_sel) * RW'(r_sel);

endmodule

@@ hw/rtl/psot_eval.sv @@
// Evaluate stage: squared distance sums against the squared radius.
`timescale 1ns / 1ps

module psot_eval #(
	parameter int COORD_BITS = 24
) (
	input  psot_pkg::stage_ctrl_t          ctrl,
	input  logic [2*(COORD_BITS+1)-1:0]    sq_x0,
	input  logic [2*(COORD_BITS+1)-1:0]    sq_x1,
	input  logic [2*(COORD_BITS+1)-1:0]    sq_y0,
	input  logic [2*(COORD_BITS+1)-1:0]    sq_y1,
	input  logic [2*COORD_BITS-1:0]        sq_r,
	output logic                           hit
);
	import psot_pkg::*;

	localparam int AW = 2 * (COORD_BITS + 1) + 1;   // sum width

	logic [AW-1:0] rr;
	logic          in00, in01, in10, in11;

	assign rr = AW'(sq_r);

	// Strict less-than for each corner pairing
	assign in00 = (AW'(sq_x0) + AW'(sq_y0)) < rr;
	assign in01 = (AW'(sq_x0) + AW'(sq_y1)) < rr;
	assign in10 = (AW'(sq_x1) + AW'(sq_y0)) < rr;
	assign in11 = (AW'(sq_x1) + AW'(sq_y1)) < rr;

	// Combine box result, corner tests and plain circle test
	assign hit = ctrl.enable && (ctrl.box_hit ||
		(ctrl.corner_test && (in00 || in01 || in10 || in11)) ||
		(ctrl.single_test && in00));

endmodule

@@ hw/rtl/planar_shape_overlap_test_unit.sv @@
// Top level of the planar shape overlap test unit: three-register pipeline.
// Path: a request accepted at in_ready passes the input, product and result
// registers in that order before its hit shows at out_valid.
// Throughput: one request per cycle, limited only by the output handshake.
// Reset: arst_n clears the stage valid flags; payload registers keep their data.
`timescale 1ns / 1ps

module planar_shape_overlap_test_unit #(
	parameter int COORD_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [2:0]                     operation,
	input  logic signed [COORD_BITS-1:0]   a_x,
	input  logic signed [COORD_BITS-1:0]   a_y,
	input  logic [COORD_BITS-2:0]          a_half_w,
	input  logic [COORD_BITS-2:0]          a_half_h,
	input  logic                           a_exist,
	input  logic signed [COORD_BITS-1:0]   b_x,
	input  logic signed [COORD_BITS-1:0]   b_y,
	input  logic [COORD_BITS-2:0]          b_half_w,
	input  logic [COORD_BITS-2:0]          b_half_h,
	input  logic                           b_exist,
	input  logic                           ignore_presence,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           hit
);
	import psot_pkg::*;

	localparam int SW = 2 * (COORD_BITS + 1);
	localparam int RW = 2 * COORD_BITS;

	// Input register
	logic                          v_s1;
	logic [2:0]                    op_s1;
	logic signed [COORD_BITS-1:0]  ax_s1, ay_s1, bx_s1, by_s1;
	logic [COORD_BITS-2:0]         aw_s1, ah_s1, bw_s1, bh_s1;
	logic                          ae_s1, be_s1, ign_s1;

	// Product register
	logic                          v_s2;
	stage_ctrl_t                   ctrl_s2;
	logic [SW-1:0]                 sqx0_s2, sqx1_s2, sqy0_s2, sqy1_s2;
	logic [RW-1:0]                 sqr_s2;

	stage_ctrl_t                   ctrl_c;
	logic [SW-1:0]                 sqx0_c, sqx1_c, sqy0_c, sqy1_c;
	logic [RW-1:0]                 sqr_c;
	logic                          hit_c;
	logic                          hit_q, out_valid_q;
	logic                          rdy1, rdy2, rdy3;

	// Stage advance: a stage moves when it is empty or its successor moves
	assign rdy3     = !out_valid_q || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	// Capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			op_s1  <= operation;
			ax_s1  <= a_x;
			ay_s1  <= a_y;
			aw_s1  <= a_half_w;
			ah_s1  <= a_half_h;
			ae_s1  <= a_exist;
			bx_s1  <= b_x;
			by_s1  <= b_y;
			bw_s1  <= b_half_w;
			bh_s1  <= b_half_h;
			be_s1  <= b_exist;
			ign_s1 <= ignore_presence;
		end
	end

	psot_prep #(
		.COORD_BITS(COORD_BITS)
	) u_prep (
		.operation      (op_s1),
		.a_x            (ax_s1),
		.a_y            (ay_s1),
		.a_half_w       (aw_s1),
		.a_half_h       (ah_s1),
		.a_exist        (ae_s1),
		.b_x            (bx_s1),
		.b_y            (by_s1),
		.b_half_w       (bw_s1),
		.b_half_h       (bh_s1),
		.b_exist        (be_s1),
		.ignore_presence(ign_s1),
		.ctrl           (ctrl_c),
		.sq_x0          (sqx0_c),
		.sq_x1          (sqx1_c),
		.sq_y0          (sqy0_c),
		.sq_y1          (sqy1_c),
		.sq_r           (sqr_c)
	);

	// Hold the squares and control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			ctrl_s2 <= ctrl_c;
			sqx0_s2 <= sqx0_c;
			sqx1_s2 <= sqx1_c;
			sqy0_s2 <= sqy0_c;
			sqy1_s2 <= sqy1_c;
			sqr_s2  <= sqr_c;
		end
	end

	psot_eval #(
		.COORD_BITS(COORD_BITS)
	) u_eval (
		.ctrl (ctrl_s2),
		.sq_x0(sqx0_s2),
		.sq_x1(sqx1_s2),
		.sq_y0(sqy0_s2),
		.sq_y1(sqy1_s2),
		.sq_r (sqr_s2),
		.hit  (hit_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy3) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			hit_q <= hit_c;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;

	// A stalled input stage keeps its request
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !rdy2) |=> (v_s1 && $stable(op_s1) && $stable(ax_s1) && $stable(bx_s1)))
		else $error("input stage lost its request while stalled");

	// A full pipeline behind a stalled output refuses new requests
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && out_valid && !out_ready) |-> !in_ready)
		else $error("request accepted into a full pipeline");

	// Disabled tests never report a hit
	a_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && rdy3 && !ctrl_s2.enable) |=> (out_valid && !hit))
		else $error("hit reported for an absent shape or unknown operation");

	// A settled box comparison on an enabled test always reports a hit
	a_box_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && rdy3 && ctrl_s2.enable && ctrl_s2.box_hit) |=> (out_valid && hit))
		else $error("box overlap not reported");

	// Accepted request reaches the product register
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && rdy2) |=> v_s2)
		else $error("request dropped between stages");

endmodule

@@ sim/planar_shape_overlap_test_unit_tb.sv @@
// Self-checking testbench for the planar shape overlap test unit.
`timescale 1ns / 1ps

module planar_shape_overlap_test_unit_tb;
	import psot_pkg::*;

	localparam int          COORD_BITS     = 24;
	localparam int          RESET_CYCLES   = 7;
	localparam int          DRAIN_CYCLES   = 16;
	localparam int unsigned CYCLE_LIMIT    = 400000;
	localparam int          RANDOM_COUNT   = 800;
	localparam logic [2:0]  FIRST_BAD_OP   = 3'd5;
	localparam logic [2:0]  LAST_BAD_OP    = 3'd7;
	localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic [COORD_BITS-2:0]        EXT_MAX   = {(COORD_BITS-1){1'b1}};

	typedef struct {
		logic [2:0]                   operation;
		logic signed [COORD_BITS-1:0] a_x;
		logic signed [COORD_BITS-1:0] a_y;
		logic [COORD_BITS-2:0]        a_half_w;
		logic [COORD_BITS-2:0]        a_half_h;
		logic                         a_exist;
		logic signed [COORD_BITS-1:0] b_x;
		logic signed [COORD_BITS-1:0] b_y;
		logic [COORD_BITS-2:0]        b_half_w;
		logic [COORD_BITS-2:0]        b_half_h;
		logic                         b_exist;
		logic                         ignore_presence;
	} shape_req_t;

	typedef struct {
		logic       hit;
		logic [2:0] operation;
		int         index;
	} hit_rec_t;

	logic                         clk             = 1'b0;
	logic                         arst_n          = 1'b0;
	logic                         in_valid        = 1'b0;
	logic                         in_ready;
	logic [2:0]                   operation       = '0;
	logic signed [COORD_BITS-1:0] a_x             = '0;
	logic signed [COORD_BITS-1:0] a_y             = '0;
	logic [COORD_BITS-2:0]        a_half_w        = '0;
	logic [COORD_BITS-2:0]        a_half_h        = '0;
	logic                         a_exist         = 1'b0;
	logic signed [COORD_BITS-1:0] b_x             = '0;
	logic signed [COORD_BITS-1:0] b_y             = '0;
	logic [COORD_BITS-2:0]        b_half_w        = '0;
	logic [COORD_BITS-2:0]        b_half_h        = '0;
	logic                         b_exist         = 1'b0;
	logic                         ignore_presence = 1'b0;
	logic                         out_valid;
	logic                         out_ready       = 1'b0;
	logic                         hit;

	shape_req_t  pending_reqs[$];
	hit_rec_t    hit_expected[$];
	shape_req_t  in_flight;
	int          n_total    = 0;
	int          n_accepted = 0;
	int          errors     = 0;
	int          send_gap   = 0;
	int          recv_stall = 0;
	int unsigned cycles     = 0;
	bit          calm       = 1'b0;

	planar_shape_overlap_test_unit #(
		.COORD_BITS(COORD_BITS)
	) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.a_x            (a_x),
		.a_y            (a_y),
		.a_half_w       (a_half_w),
		.a_half_h       (a_half_h),
		.a_exist        (a_exist),
		.b_x            (b_x),
		.b_y            (b_y),
		.b_half_w       (b_half_w),
		.b_half_h       (b_half_h),
		.b_exist        (b_exist),
		.ignore_presence(ignore_presence),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.hit            (hit)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Closed box around (cx, cy) contains the point
	function automatic bit box_contains(longint cx, longint cy, longint w, longint h,
			longint px, longint py);
		return (cx - w <= px) && (px <= cx + w) && (cy - h <= py) && (py <= cy + h);
	endfunction

	// Squared distance strictly below the squared radius
	function automatic bit disc_contains(longint cx, longint cy, longint r,
			longint px, longint py);
		longint dx;
		longint dy;
		dx = px - cx;
		dy = py - cy;
		return (dx * dx + dy * dy) < (r * r);
	endfunction

	// Expected hit for one request
	function automatic logic overlap_hit(shape_req_t r);
		longint ax;
		longint ay;
		longint aw;
		longint ah;
		longint bx;
		longint by;
		longint bw;
		longint bh;
		bit     b_shape;
		bit     enabled;
		ax = longint'(r.a_x);
		ay = longint'(r.a_y);
		aw = longint'(r.a_half_w);
		ah = longint'(r.a_half_h);
		bx = longint'(r.b_x);
		by = longint'(r.b_y);
		bw = longint'(r.b_half_w);
		bh = longint'(r.b_half_h);
		b_shape = (r.operation == OP_BOX_BOX) || (r.operation == OP_BOX_CIRC) ||
			(r.operation == OP_CIRC_CIRC);
		enabled = r.ignore_presence || (r.a_exist && (r.b_exist || !b_shape));
		if (!enabled)
			return 1'b0;
		case (r.operation)
			OP_PT_BOX: return box_contains(ax, ay, aw, ah, bx, by);
			OP_BOX_BOX: return (ax - aw <= bx + bw) && (bx - bw <= ax + aw) &&
				(ay - ah <= by + bh) && (by - bh <= ay + ah);
			OP_BOX_CIRC: return box_contains(ax, ay, aw, ah + bw, bx, by) ||
				box_contains(ax, ay, aw + bw, ah, bx, by) ||
				disc_contains(bx, by, bw, ax - aw, ay - ah) ||
				disc_contains(bx, by, bw, ax - aw, ay + ah) ||
				disc_contains(bx, by, bw, ax + aw, ay - ah) ||
				disc_contains(bx, by, bw, ax + aw, ay + ah);
			OP_PT_CIRC: return disc_contains(ax, ay, aw, bx, by);
			OP_CIRC_CIRC: return disc_contains(ax, ay, aw + bw, bx, by);
			default: return 1'b0;
		endcase
	endfunction

	function automatic shape_req_t make_req(logic [2:0] op,
			longint ax, longint ay, longint aw, longint ah, logic ae,
			longint bx, longint by, longint bw, longint bh, logic be, logic ign);
		shape_req_t r;
		r.operation       = op;
		r.a_x             = COORD_BITS'(ax);
		r.a_y             = COORD_BITS'(ay);
		r.a_half_w        = (COORD_BITS-1)'(aw);
		r.a_half_h        = (COORD_BITS-1)'(ah);
		r.a_exist         = ae;
		r.b_x             = COORD_BITS'(bx);
		r.b_y             = COORD_BITS'(by);
		r.b_half_w        = (COORD_BITS-1)'(bw);
		r.b_half_h        = (COORD_BITS-1)'(bh);
		r.b_exist         = be;
		r.ignore_presence = ign;
		return r;
	endfunction

	// Mostly short gaps, a few long ones, none during calm stretches
	function automatic int pick_idle();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic longint pick_extent();
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return 0;
		if (roll < 11)
			return longint'($urandom_range(0, 255));
		if (roll < 17)
			return longint'($urandom_range(0, 65536));
		return longint'($urandom & EXT_MAX);
	endfunction

	function automatic longint pick_coord();
		if ($urandom_range(0, 3) == 0)
			return longint'(COORD_BITS'($signed($urandom)));
		return longint'($urandom_range(0, 131072)) - 65536;
	endfunction

	// Offset of B from A around the reach where the test flips
	function automatic longint pick_offset(longint reach);
		int unsigned roll;
		longint      mag_off;
		roll = $urandom_range(0, 9);
		if (roll < 3)
			mag_off = reach + longint'($urandom_range(0, 2)) - 1;
		else if (roll < 8)
			mag_off = longint'($urandom_range(0, int'(reach * 2 + 2)));
		else
			return pick_coord();
		return $urandom_range(0, 1) ? -mag_off : mag_off;
	endfunction

	// Random request, mostly with B placed near the boundary of A
	function automatic shape_req_t random_req();
		shape_req_t  r;
		logic [2:0]  op;
		longint      ax;
		longint      ay;
		longint      aw;
		longint      ah;
		longint      bw;
		longint      bh;
		longint      reach_x;
		longint      reach_y;
		logic        ae;
		logic        be;
		logic        ign;
		if ($urandom_range(0, 32) == 0)
			op = 3'($urandom_range(FIRST_BAD_OP, LAST_BAD_OP));
		else
			op = 3'($urandom_range(OP_PT_BOX, OP_CIRC_CIRC));
		ax = pick_coord();
		ay = pick_coord();
		aw = pick_extent();
		ah = pick_extent();
		bw = pick_extent();
		bh = pick_extent();
		case (op)
			OP_PT_BOX: begin
				reach_x = aw;
				reach_y = ah;
			end
			OP_BOX_BOX: begin
				reach_x = aw + bw;
				reach_y = ah + bh;
			end
			OP_BOX_CIRC: begin
				reach_x = aw + bw;
				reach_y = ah + bw;
			end
			OP_PT_CIRC: begin
				reach_x = aw;
				reach_y = aw;
			end
			default: begin
				reach_x = aw + bw;
				reach_y = aw + bw;
			end
		endcase
		ae  = ($urandom_range(0, 9) != 0);
		be  = ($urandom_range(0, 9) != 0);
		ign = ($urandom_range(0, 9) == 0);
		r = make_req(op, ax, ay, aw, ah, ae, ax + pick_offset(reach_x),
			ay + pick_offset(reach_y), bw, bh, be, ign);
		return r;
	endfunction

	// Fill the request queue: directed cases first, then random
	initial begin
		// point in box: inclusive corner, one past, single-point box
		pending_reqs.push_back(make_req(OP_PT_BOX, 100, 100, 10, 20, 1, 110, 120, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_PT_BOX, 100, 100, 10, 20, 1, 111, 120, 0, 0, 1, 0));
		pending_reqs.push_back(make_req(OP_PT_BOX, -5, 7, 0, 0, 1, -5, 7, 0, 0, 1, 0));
		pending_reqs.push_back(make_req(OP_PT_BOX, COORD_MIN, COORD_MAX, EXT_MAX, EXT_MAX, 1,
			COORD_MAX, COORD_MIN, EXT_MAX, EXT_MAX, 1, 0));
		// box against box: touching, one apart, extreme corners
		pending_reqs.push_back(make_req(OP_BOX_BOX, 0, 0, 10, 10, 1, 25, 20, 15, 10, 1, 0));
		pending_reqs.push_back(make_req(OP_BOX_BOX, 0, 0, 10, 10, 1, 26, 0, 15, 10, 1, 0));
		pending_reqs.push_back(make_req(OP_BOX_BOX, COORD_MIN, COORD_MIN, EXT_MAX, EXT_MAX, 1,
			COORD_MAX, COORD_MAX, EXT_MAX, EXT_MAX, 1, 0));
		pending_reqs.push_back(make_req(OP_BOX_BOX, COORD_MIN, COORD_MIN, 0, 0, 1,
			COORD_MAX, COORD_MAX, 0, 0, 1, 0));
		// box against circle: grown edge, corner at exactly the radius, just inside
		pending_reqs.push_back(make_req(OP_BOX_CIRC, 0, 0, 3, 4, 1, 0, 9, 5, 0, 1, 0));
		pending_reqs.push_back(make_req(OP_BOX_CIRC, 0, 0, 3, 4, 1, 6, 8, 5, 0, 1, 0));
		pending_reqs.push_back(make_req(OP_BOX_CIRC, 0, 0, 3, 4, 1, 6, 8, 6, 0, 1, 0));
		pending_reqs.push_back(make_req(OP_BOX_CIRC, COORD_MAX, COORD_MAX, EXT_MAX, EXT_MAX, 1,
			COORD_MIN, COORD_MIN, EXT_MAX, EXT_MAX, 1, 0));
		// point in circle: on the rim, inside, zero radius
		pending_reqs.push_back(make_req(OP_PT_CIRC, 0, 0, 5, 0, 1, 3, 4, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_PT_CIRC, 0, 0, 6, 0, 1, 3, 4, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_PT_CIRC, 9, 9, 0, EXT_MAX, 1, 9, 9, 0, 0, 1, 0));
		// circle against circle: extremes, touching rims
		pending_reqs.push_back(make_req(OP_CIRC_CIRC, COORD_MIN, COORD_MIN, EXT_MAX, 0, 1,
			COORD_MAX, COORD_MAX, EXT_MAX, 0, 1, 0));
		pending_reqs.push_back(make_req(OP_CIRC_CIRC, 0, 0, 2, 0, 1, 3, 4, 3, 0, 1, 0));
		// absent shapes and the override
		pending_reqs.push_back(make_req(OP_PT_BOX, 0, 0, 5, 5, 0, 0, 0, 0, 0, 1, 0));
		pending_reqs.push_back(make_req(OP_BOX_BOX, 0, 0, 5, 5, 1, 0, 0, 5, 5, 0, 0));
		pending_reqs.push_back(make_req(OP_PT_CIRC, 0, 0, 5, 5, 1, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_CIRC_CIRC, 0, 0, 5, 5, 0, 0, 0, 5, 5, 0, 1));
		// unknown operations on shapes that would overlap
		for (int op = FIRST_BAD_OP; op <= LAST_BAD_OP; op++)
			pending_reqs.push_back(make_req(3'(op), 0, 0, 50, 50, 1, 0, 0, 50, 50, 1, 1));
		repeat (RANDOM_COUNT)
			pending_reqs.push_back(random_req());
		n_total = pending_reqs.size();
	end

	// Release reset once, then wait for every request and its hit, then report
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (n_total == 0 || n_accepted != n_total || hit_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (hit_expected.size() != 0)
			errors++;
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Count cycles, switch calm stretches, stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 256 == 0)
			calm <= ($urandom_range(0, 3) == 0);
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d requests accepted",
				cycles, n_accepted, n_total);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Drive requests: predict on acceptance, then advance or hold off
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				hit_expected.push_back('{hit: overlap_hit(in_flight),
					operation: in_flight.operation, index: n_accepted});
				n_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					in_flight = pending_reqs.pop_front();
					operation       <= in_flight.operation;
					a_x             <= in_flight.a_x;
					a_y             <= in_flight.a_y;
					a_half_w        <= in_flight.a_half_w;
					a_half_h        <= in_flight.a_half_h;
					a_exist         <= in_flight.a_exist;
					b_x             <= in_flight.b_x;
					b_y             <= in_flight.b_y;
					b_half_w        <= in_flight.b_half_w;
					b_half_h        <= in_flight.b_half_h;
					b_exist         <= in_flight.b_exist;
					ignore_presence <= in_flight.ignore_presence;
					in_valid        <= 1'b1;
					send_gap = pick_idle();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Check each hit against the oldest prediction; stall the output at random
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (hit_expected.size() == 0) begin
					errors++;
					$display("%0t: unexpected hit output %0b with no request pending",
						$time, hit);
				end else begin
					hit_rec_t exp_rec;
					exp_rec = hit_expected.pop_front();
					if (hit !== exp_rec.hit) begin
						errors++;
						$display("%0t: request %0d op %0d hit expected %0b actual %0b",
							$time, exp_rec.index, exp_rec.operation, exp_rec.hit, hit);
					end
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 7) == 0)
					recv_stall = pick_idle();
			end
		end
	end

endmodule

@@ files.f @@
hw/rtl/psot_pkg.sv
hw/rtl/psot_prep.sv
hw/rtl/psot_eval.sv
hw/rtl/planar_shape_overlap_test_unit.sv
sim/planar_shape_overlap_test_unit_tb.sv
